>>> rtl/core/wfpa_pkg.sv
`default_nettype none
package wfpa_pkg;

    localparam int PartitionsDefault = 16;

    localparam int AmountWidth = 16;
    localparam int SlotWidth   = 4;

    // input command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // result status codes
    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_NOFIT = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;
    localparam logic [1:0] STS_RANGE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FULL,
        OP_BAD,
        OP_RANGE,
        OP_RD_ISSUE,
        OP_RD_DONE,
        OP_SCAN_START,
        OP_SCAN_STEP,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_t;

    typedef struct packed {
        logic out_free;
        logic table_full;
        logic slot_ok;
        logic scan_more;
        logic pending;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/worst_fit_partition_allocator_unit.sv
`default_nettype none
// channel  | direction | ports
// ---------+-----------+--------------------------------------------
// s_       | in        | s_valid s_ready s_command s_amount s_slot
// m_       | out       | m_valid m_ready m_status m_chosen m_remaining
//
// Load, bad command and out-of-range read: result registered straight from the beat.
// Read: one memory read, then the result register. Allocate: a scan, then a commit,
// paced by the one-entry-per-cycle scan through the single read port of the memory.
// Synchronous active-low reset clears the loaded count and the output valid;
// partition memory holds garbage until loaded. One item is in work at a time;
// a new beat is taken while the previous result is being drained by m_ready.
module worst_fit_partition_allocator_unit #(
    parameter int PARTITIONS = wfpa_pkg::PartitionsDefault
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_command,
    input  wire logic [wfpa_pkg::AmountWidth-1:0] s_amount,
    input  wire logic [wfpa_pkg::SlotWidth-1:0]   s_slot,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_status,
    output logic [wfpa_pkg::SlotWidth-1:0]        m_chosen,
    output logic [wfpa_pkg::AmountWidth-1:0]      m_remaining
);
    import wfpa_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    wfpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    wfpa_dp #(
        .PARTITIONS (PARTITIONS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_amount    (s_amount),
        .s_slot      (s_slot),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_chosen    (m_chosen),
        .m_remaining (m_remaining),
        .ctrl        (ctrl),
        .stat        (stat)
    );

endmodule
`default_nettype wire

>>> rtl/core/wfpa_ctrl.sv
`default_nettype none
module wfpa_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_command,
    input  wire wfpa_pkg::stat_t   stat,
    output wfpa_pkg::ctrl_t        ctrl
);
    import wfpa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign take = (state_reg == ST_IDLE) && s_valid && stat.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (s_command == CMD_ALLOC) begin
                        state_next = ST_SCAN;
                    end else if (s_command == CMD_READ && stat.slot_ok) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SCAN: begin
                if (!stat.scan_more && !stat.pending) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        ctrl.op = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = stat.out_free;
                if (take) begin
                    case (s_command)
                        CMD_LOAD:  ctrl.op = stat.table_full ? OP_FULL : OP_LOAD;
                        CMD_ALLOC: ctrl.op = OP_SCAN_START;
                        CMD_READ:  ctrl.op = stat.slot_ok ? OP_RD_ISSUE : OP_RANGE;
                        default:   ctrl.op = OP_BAD;
                    endcase
                end
            end
            ST_SCAN: begin
                ctrl.op = (stat.scan_more || stat.pending) ? OP_SCAN_STEP : OP_COMMIT;
            end
            ST_READ: begin
                ctrl.op = OP_RD_DONE;
            end
            default: begin
                ctrl.op = OP_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/wfpa_dp.sv
`default_nettype none
module wfpa_dp #(
    parameter int PARTITIONS = wfpa_pkg::PartitionsDefault
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [wfpa_pkg::AmountWidth-1:0] s_amount,
    input  wire logic [wfpa_pkg::SlotWidth-1:0]   s_slot,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_status,
    output logic [wfpa_pkg::SlotWidth-1:0]        m_chosen,
    output logic [wfpa_pkg::AmountWidth-1:0]      m_remaining,
    input  wire wfpa_pkg::ctrl_t                  ctrl,
    output wfpa_pkg::stat_t                       stat
);
    import wfpa_pkg::*;

    localparam int AW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CW = $clog2(PARTITIONS + 1);

    logic [AmountWidth-1:0] mem [PARTITIONS];
    logic [AmountWidth-1:0] rd_data_reg;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [AmountWidth-1:0] wr_data;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          scan_idx_reg;
    logic                   pending_reg;
    logic [AW-1:0]          pend_idx_reg;
    logic                   found_reg;
    logic [AW-1:0]          best_reg;
    logic [AmountWidth-1:0] best_size_reg;
    logic [AmountWidth-1:0] req_reg;
    logic [SlotWidth-1:0]   slot_reg;

    logic                   m_valid_reg;
    logic [1:0]             status_reg;
    logic [SlotWidth-1:0]   chosen_reg;
    logic [AmountWidth-1:0] remaining_reg;

    logic [AW+SlotWidth-1:0] slot_ext;
    logic [CW+SlotWidth-1:0] count_ext;
    logic [AW+SlotWidth-1:0] best_ext;
    logic [AmountWidth-1:0]  left_size;
    logic                    better;
    logic                    out_load;

    assign slot_ext  = (AW + SlotWidth)'(s_slot);
    assign count_ext = (CW + SlotWidth)'(count_reg);
    assign best_ext  = (AW + SlotWidth)'(best_reg);
    assign left_size = best_size_reg - req_reg;
    assign better    = (rd_data_reg >= req_reg) && (!found_reg || rd_data_reg > best_size_reg);

    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.table_full = (count_reg == CW'(PARTITIONS));
    assign stat.slot_ok    = (CW + SlotWidth)'(s_slot) < count_ext;
    assign stat.scan_more  = scan_idx_reg < count_reg;
    assign stat.pending    = pending_reg;

    assign rd_addr = (ctrl.op == OP_RD_ISSUE) ? slot_ext[AW-1:0] : scan_idx_reg[AW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = s_amount;
        if (ctrl.op == OP_LOAD) begin
            wr_en = 1'b1;
        end else if (ctrl.op == OP_COMMIT && found_reg) begin
            wr_en   = 1'b1;
            wr_addr = best_reg;
            wr_data = left_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end else begin
            if (ctrl.op == OP_LOAD) begin
                count_reg <= count_reg + CW'(1);
            end
            if (ctrl.op == OP_SCAN_START) begin
                pending_reg <= 1'b0;
            end else if (ctrl.op == OP_SCAN_STEP) begin
                pending_reg <= stat.scan_more;
            end
        end
    end

    // scan: each read is registered into rd_data_reg and compared at the next scan step
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_SCAN_START: begin
                req_reg      <= s_amount;
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            OP_SCAN_STEP: begin
                if (stat.scan_more) begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                    pend_idx_reg <= scan_idx_reg[AW-1:0];
                end
                if (pending_reg && better) begin
                    found_reg     <= 1'b1;
                    best_reg      <= pend_idx_reg;
                    best_size_reg <= rd_data_reg;
                end
            end
            OP_RD_ISSUE: begin
                slot_reg <= s_slot;
            end
            default: begin
            end
        endcase
    end

    assign out_load = (ctrl.op == OP_LOAD) || (ctrl.op == OP_FULL) || (ctrl.op == OP_BAD)
                   || (ctrl.op == OP_RANGE) || (ctrl.op == OP_RD_DONE)
                   || (ctrl.op == OP_COMMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LOAD: begin
                status_reg    <= STS_DONE;
                chosen_reg    <= count_ext[SlotWidth-1:0];
                remaining_reg <= s_amount;
            end
            OP_FULL: begin
                status_reg    <= STS_FULL;
                chosen_reg    <= '0;
                remaining_reg <= '0;
            end
            OP_BAD: begin
                status_reg    <= STS_RANGE;
                chosen_reg    <= '0;
                remaining_reg <= '0;
            end
            OP_RANGE: begin
                status_reg    <= STS_RANGE;
                chosen_reg    <= s_slot;
                remaining_reg <= '0;
            end
            OP_RD_DONE: begin
                status_reg    <= STS_DONE;
                chosen_reg    <= slot_reg;
                remaining_reg <= rd_data_reg;
            end
            OP_COMMIT: begin
                if (found_reg) begin
                    status_reg    <= STS_DONE;
                    chosen_reg    <= best_ext[SlotWidth-1:0];
                    remaining_reg <= left_size;
                end else begin
                    status_reg    <= STS_NOFIT;
                    chosen_reg    <= '0;
                    remaining_reg <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_chosen    = chosen_reg;
    assign m_remaining = remaining_reg;

endmodule
`default_nettype wire

>>> verif/wfpa_checker.sv
`default_nettype none
module wfpa_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  wire logic [1:0]                       s_command,
    input  wire logic [wfpa_pkg::AmountWidth-1:0] s_amount,
    input  wire logic [wfpa_pkg::SlotWidth-1:0]   s_slot,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    input  wire logic [1:0]                       m_status,
    input  wire logic [wfpa_pkg::SlotWidth-1:0]   m_chosen,
    input  wire logic [wfpa_pkg::AmountWidth-1:0] m_remaining,
    output int unsigned                           fail_count,
    output int unsigned                           pending,
    output int unsigned                           checked
);
    import wfpa_pkg::*;

    typedef struct packed {
        logic [1:0]             status;
        logic [SlotWidth-1:0]   chosen;
        logic [AmountWidth-1:0] remaining;
    } alloc_result_t;

    logic [AmountWidth-1:0] part_free [PartitionsDefault];
    int                     part_count;
    alloc_result_t          outstanding[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        part_count = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t checker: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Worst fit: largest free size that still covers the request, lowest index on ties.
    function automatic alloc_result_t predict_beat(
        input logic [1:0]             cmd,
        input logic [AmountWidth-1:0] amt,
        input logic [SlotWidth-1:0]   slt
    );
        alloc_result_t          r;
        logic                   found;
        int                     best;
        logic [AmountWidth-1:0] best_size;
        r.status    = STS_RANGE;
        r.chosen    = '0;
        r.remaining = '0;
        case (cmd)
            CMD_LOAD: begin
                if (part_count >= PartitionsDefault) begin
                    r.status = STS_FULL;
                end else begin
                    part_free[part_count] = amt;
                    r.status    = STS_DONE;
                    r.chosen    = SlotWidth'(part_count);
                    r.remaining = amt;
                    part_count++;
                end
            end
            CMD_ALLOC: begin
                found     = 1'b0;
                best      = 0;
                best_size = '0;
                for (int j = 0; j < part_count; j++) begin
                    if (part_free[j] >= amt && (!found || part_free[j] > best_size)) begin
                        found     = 1'b1;
                        best      = j;
                        best_size = part_free[j];
                    end
                end
                if (found) begin
                    part_free[best] = best_size - amt;
                    r.status    = STS_DONE;
                    r.chosen    = SlotWidth'(best);
                    r.remaining = best_size - amt;
                end else begin
                    r.status = STS_NOFIT;
                end
            end
            CMD_READ: begin
                r.chosen = slt;
                if (int'(slt) < part_count) begin
                    r.status    = STS_DONE;
                    r.remaining = part_free[slt];
                end
            end
            default: begin
                r.status = STS_RANGE;
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        alloc_result_t want;
        if (!aresetn) begin
            part_count = 0;
            outstanding.delete();
        end else begin
            // retire first: a beat taken on this edge cannot have its result yet
            if (m_valid && m_ready) begin
                checked++;
                if (outstanding.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding, status", m_status, -1);
                end else begin
                    want = outstanding.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_chosen !== want.chosen)
                        report_mismatch("chosen", m_chosen, want.chosen);
                    if (m_remaining !== want.remaining)
                        report_mismatch("remaining", m_remaining, want.remaining);
                end
            end
            if (s_valid && s_ready)
                outstanding.push_back(predict_beat(s_command, s_amount, s_slot));
        end
        pending = outstanding.size();
    end

endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;
    import wfpa_pkg::*;

    localparam logic [1:0]  CmdUnused   = 2'd3;
    localparam int unsigned CycleLimit  = 500000;
    localparam int          RandomBeats = 800;
    localparam int          Phases      = 8;
    localparam int          DrainCycles = 40;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [1:0]             s_command;
    logic [AmountWidth-1:0] s_amount;
    logic [SlotWidth-1:0]   s_slot;
    logic                   m_valid;
    logic                   m_ready;
    logic [1:0]             m_status;
    logic [SlotWidth-1:0]   m_chosen;
    logic [AmountWidth-1:0] m_remaining;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned cycle_count = 0;
    int unsigned hold_cnt    = 0;
    int unsigned n_load      = 0;
    int unsigned n_alloc     = 0;
    int unsigned n_read      = 0;
    int unsigned n_bad       = 0;
    bit          send_idle_on;
    bit          recv_idle_on;

    worst_fit_partition_allocator_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_amount    (s_amount),
        .s_slot      (s_slot),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_chosen    (m_chosen),
        .m_remaining (m_remaining)
    );

    wfpa_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_amount    (s_amount),
        .s_slot      (s_slot),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_chosen    (m_chosen),
        .m_remaining (m_remaining),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge aclk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (recv_idle_on && $urandom_range(0, 3) == 0)
                hold_cnt <= gap_len();
        end
    end

    task automatic send_beat(
        input logic [1:0]             cmd,
        input logic [AmountWidth-1:0] amt,
        input logic [SlotWidth-1:0]   slt
    );
        int unsigned gap;
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_amount  <= amt;
        s_slot    <= slt;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        case (cmd)
            CMD_LOAD:  n_load++;
            CMD_ALLOC: n_alloc++;
            CMD_READ:  n_read++;
            default:   n_bad++;
        endcase
        if (send_idle_on && $urandom_range(0, 2) == 0) begin
            gap = gap_len();
            s_valid   <= 1'b0;
            s_command <= 2'($urandom);
            s_amount  <= AmountWidth'($urandom);
            s_slot    <= SlotWidth'($urandom);
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_random();
        int unsigned            roll;
        logic [1:0]             cmd;
        logic [AmountWidth-1:0] amt;
        logic [SlotWidth-1:0]   slt;
        roll = $urandom_range(0, 99);
        slt  = SlotWidth'($urandom);
        amt  = AmountWidth'($urandom);
        if (roll < 15) begin
            cmd  = CMD_LOAD;
            roll = $urandom_range(0, 9);
            if (roll < 2)
                amt = '1;
            else if (roll == 2)
                amt = '0;
            else if (roll < 7)
                amt = AmountWidth'($urandom_range(20000, 65535));
        end else if (roll < 70) begin
            cmd  = CMD_ALLOC;
            roll = $urandom_range(0, 19);
            if (roll < 2)
                amt = '0;
            else if (roll < 10)
                amt = AmountWidth'($urandom_range(1, 255));
            else if (roll < 16)
                amt = AmountWidth'($urandom_range(256, 4095));
            else if (roll < 19)
                amt = AmountWidth'($urandom_range(4096, 40000));
        end else if (roll < 95) begin
            cmd = CMD_READ;
        end else begin
            cmd = CmdUnused;
        end
        send_beat(cmd, amt, slt);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = CMD_LOAD;
        s_amount     = '0;
        s_slot       = '0;
        m_ready      = 1'b0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // empty table
        send_beat(CMD_ALLOC, 16'd0, 4'd0);
        send_beat(CMD_READ, 16'd0, 4'd0);
        send_beat(CmdUnused, 16'hFFFF, 4'hF);
        // zero-size partition, zero request fits it and leaves it as is
        send_beat(CMD_LOAD, 16'd0, 4'd0);
        send_beat(CMD_ALLOC, 16'd0, 4'd0);
        send_beat(CMD_ALLOC, 16'd1, 4'd0);
        // tie on the largest size goes to the lower index
        send_beat(CMD_LOAD, 16'hFFFF, 4'd0);
        send_beat(CMD_LOAD, 16'hFFFF, 4'hF);
        send_beat(CMD_ALLOC, 16'hFFFF, 4'd0);
        send_beat(CMD_ALLOC, 16'hFFFF, 4'd0);
        send_beat(CMD_LOAD, 16'd1000, 4'd0);
        send_beat(CMD_LOAD, 16'd3000, 4'd0);
        send_beat(CMD_ALLOC, 16'd0, 4'd0);
        send_beat(CMD_ALLOC, 16'd3000, 4'd0);
        send_beat(CMD_ALLOC, 16'd1001, 4'd0);
        send_beat(CMD_ALLOC, 16'd600, 4'd0);
        send_beat(CMD_READ, 16'd0, 4'd3);
        send_beat(CMD_READ, 16'hFFFF, 4'hF);
        send_beat(CMD_READ, 16'd0, 4'd4);
        send_beat(CmdUnused, 16'd0, 4'd0);

        for (int phase = 0; phase < Phases; phase++) begin
            // hold off once until the block has drained completely
            if (phase == Phases / 2) begin
                s_valid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end
            send_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            recv_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            if (phase == Phases - 1) begin
                send_idle_on = 1'b1;
                recv_idle_on = 1'b1;
            end
            for (int k = 0; k < RandomBeats / Phases; k++)
                send_random();
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
        $display("run: %0d loads, %0d allocates, %0d reads, %0d unused commands",
                 n_load, n_alloc, n_read, n_bad);
        $display("run: %0d results compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
